FILE: sv/assert_macros.svh
// Assertion macros used by the boundary finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

FILE: sv/hmbf_pkg.sv
// Constants, types and pattern tables for the HTTP message boundary finder.
package hmbf_pkg;

  localparam int POS_WIDTH = 32;
  localparam int POS_EXT_WIDTH = POS_WIDTH + 1;
  localparam int BOUND_WIDTH = 32;
  localparam int WIN_DEPTH = 9;
  localparam int PAT_COUNT = 11;
  localparam int PAT_REQ_COUNT = 9;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH = 32;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [POS_EXT_WIDTH-1:0] pos_ext_t;
  typedef logic [WIN_DEPTH-1:0][7:0] win_t;
  typedef logic [8*WIN_DEPTH-1:0] pat_text_t;
  typedef logic [3:0] pat_len_t;
  typedef logic [2:0] seg_count_t;

  localparam pos_t POS_MAX = '1;
  localparam seg_count_t SEG_MAX = 3'd7;
  localparam seg_count_t SEG_MARKER_MIN = 3'd4;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_RESPONSE = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MESSAGE_KIND = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_OFFSET = 1'd1;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  // Text is right-aligned: byte k holds the k-th character counted from the end.
  localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
    pat_text_t'("GET "), pat_text_t'("HEAD "), pat_text_t'("POST "),
    pat_text_t'("PUT "), pat_text_t'("DELETE "), pat_text_t'("CONNECT "),
    pat_text_t'("OPTIONS "), pat_text_t'("TRACE "), pat_text_t'("PATCH "),
    pat_text_t'("HTTP/1.1 "), pat_text_t'("HTTP/1.0 ")
  };

  localparam pat_len_t PAT_LEN [PAT_COUNT] = '{
    4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd8, 4'd6, 4'd6, 4'd9, 4'd9
  };

  function automatic logic pat_match(win_t win, int idx);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if ((k < int'(PAT_LEN[idx])) && (win[k] != PAT_TEXT[idx][8*k +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

FILE: sv/http_message_boundary_finder.sv
// Top level of the HTTP message boundary finder: byte scanner and result register.
//
// The block takes one byte word per cycle unless a held result stalls it: every
// pattern compare runs in parallel over a nine-byte window between the input
// port and a single result register, so a word is accepted in every cycle in
// which the result register is empty or being drained. A result appears in the
// cycle after the byte that causes it. Each buffer, ended by a word with
// last_byte set, yields exactly one result: the first boundary found, or
// not-found on the final byte. Write the configuration registers only while
// no result is pending.
`include "assert_macros.svh"

module http_message_boundary_finder import hmbf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       found,
  output logic [BOUND_WIDTH-1:0]     boundary_pos,
  output logic                       position_overflow
);

  logic [1:0]             message_kind;
  logic [BOUND_WIDTH-1:0] base_offset;

  win_t       byte_window;
  seg_count_t segment_count;
  pos_t       match_start;
  logic       match_valid;
  pos_t       byte_position;
  logic       result_given;
  logic       overflow_seen;

  logic                   in_fire;
  logic                   active;
  logic                   kind_ok;
  win_t                   window_next;
  seg_count_t             segment_count_next;
  logic                   pos_sat;
  pos_ext_t               pos_plus;
  logic [PAT_COUNT-1:0]   hit;
  logic                   any_hit;
  pat_len_t               best_len;
  pos_t                   cand_start;
  logic                   take;
  pos_t                   match_start_next;
  logic                   match_valid_next;
  logic                   marker;
  logic                   report;
  logic                   overflow_seen_next;
  logic                   emit;
  logic [BOUND_WIDTH-1:0] boundary_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    active             = !result_given;
    kind_ok            = (message_kind == KIND_REQUEST) || (message_kind == KIND_RESPONSE);
    window_next        = {byte_window[WIN_DEPTH-2:0], data_byte};
    segment_count_next = (segment_count == SEG_MAX) ? SEG_MAX : segment_count + 3'd1;
    pos_sat            = (byte_position == POS_MAX);
    pos_plus           = pos_ext_t'(byte_position) + pos_ext_t'(1);

    for (int i = 0; i < PAT_COUNT; i++) begin
      hit[i] = ((i < PAT_REQ_COUNT) ? (message_kind == KIND_REQUEST)
                                    : (message_kind == KIND_RESPONSE)) &&
               pat_match(window_next, i) &&
               (pos_plus >= pos_ext_t'(PAT_LEN[i]));
    end

    // The shortest matching pattern has the latest start.
    any_hit  = |hit;
    best_len = '1;
    for (int i = 0; i < PAT_COUNT; i++) begin
      if (hit[i] && (PAT_LEN[i] < best_len)) begin
        best_len = PAT_LEN[i];
      end
    end
    cand_start = pos_t'(pos_plus - pos_ext_t'(best_len));

    take             = any_hit && (!match_valid || (cand_start > match_start));
    match_start_next = take ? cand_start : match_start;
    match_valid_next = match_valid || any_hit;

    marker = kind_ok && (segment_count_next >= SEG_MARKER_MIN) &&
             (window_next[0] == CHAR_LF) && (window_next[1] == CHAR_CR) &&
             (window_next[2] == CHAR_LF) && (window_next[3] == CHAR_CR);

    report             = active && marker && match_valid_next;
    overflow_seen_next = overflow_seen || (active && pos_sat);
    emit               = report || (last_byte && !result_given);
    boundary_next      = report ? base_offset + BOUND_WIDTH'(match_start_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_kind <= KIND_REQUEST;
      base_offset  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MESSAGE_KIND: message_kind <= cfg_data[1:0];
        CFG_BASE_OFFSET:  base_offset  <= cfg_data[BOUND_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window   <= '0;
      segment_count <= '0;
      match_start   <= '0;
      match_valid   <= 1'b0;
      byte_position <= '0;
      result_given  <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (in_fire) begin
      if (last_byte) begin
        byte_window   <= '0;
        segment_count <= '0;
        match_start   <= '0;
        match_valid   <= 1'b0;
        byte_position <= '0;
        result_given  <= 1'b0;
        overflow_seen <= 1'b0;
      end else if (active) begin
        byte_window   <= window_next;
        segment_count <= (marker && !match_valid_next) ? '0 : segment_count_next;
        match_start   <= match_start_next;
        match_valid   <= match_valid_next;
        byte_position <= pos_sat ? byte_position : pos_t'(pos_plus);
        result_given  <= report;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (in_fire && emit) begin
      found             <= report;
      boundary_pos      <= boundary_next;
      position_overflow <= overflow_seen_next;
    end
  end

  `ASSERT_IMPLIES(a_notfound_zero, out_valid && !found, boundary_pos == '0)
  `ASSERT_NEXT(a_last_clears, in_fire && last_byte, (byte_position == '0) && !result_given)
  `ASSERT_IMPLIES(a_given_has_match, result_given, match_valid)
  `ASSERT_IMPLIES(a_overflow_saturated, overflow_seen, byte_position == POS_MAX)

endmodule
